FILE: hdl/pscc_pkg.sv
// ----------------------------------------------------------------------------
// PID steering controller package
// Fixed widths, register indexes, mode codes and reset values shared by the
// PID steering controller modules.
// ----------------------------------------------------------------------------
package pscc_pkg;

	// Fixed field widths.
	localparam int GAIN_W     = 24;
	localparam int DRIVE_W    = 48;
	localparam int MAG_W      = 32;
	localparam int LIMIT_W    = 19;
	localparam int MODE_W     = 3;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Depth of the queue between the front and back ends (a power of two).
	localparam int QUEUE_DEPTH = 4;

	// Register reset values.
	localparam int SETPOINT_RESET = 300;
	localparam int GAIN_P_RESET   = 524;
	localparam int GAIN_I_RESET   = 328;
	localparam int GAIN_D_RESET   = 13107;
	localparam int BIAS_RESET     = 0;
	localparam int LIMIT_RESET    = 6;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_SETPOINT = 3'd0,
		REG_MODE     = 3'd1,
		REG_GAIN_P   = 3'd2,
		REG_GAIN_I   = 3'd3,
		REG_GAIN_D   = 3'd4,
		REG_BIAS     = 3'd5,
		REG_LIMIT    = 3'd6
	} reg_idx_t;

	// Controller modes.
	typedef enum logic [MODE_W-1:0] {
		MODE_P   = 3'd0,
		MODE_I   = 3'd1,
		MODE_D   = 3'd2,
		MODE_PI  = 3'd3,
		MODE_PD  = 3'd4,
		MODE_ID  = 3'd5,
		MODE_PID = 3'd6,
		MODE_OFF = 3'd7
	} mode_t;

	// Which terms make up the drive.
	typedef struct packed {
		logic use_p;
		logic use_i;
		logic use_d;
		logic use_bias;
	} term_sel_t;

	function automatic term_sel_t decode_mode(mode_t m);
		term_sel_t sel;
		sel = '0;
		case (m)
			MODE_P:   sel = '{use_p: 1'b1, use_i: 1'b0, use_d: 1'b0, use_bias: 1'b1};
			MODE_I:   sel = '{use_p: 1'b0, use_i: 1'b1, use_d: 1'b0, use_bias: 1'b1};
			MODE_D:   sel = '{use_p: 1'b0, use_i: 1'b0, use_d: 1'b1, use_bias: 1'b1};
			MODE_PI:  sel = '{use_p: 1'b1, use_i: 1'b1, use_d: 1'b0, use_bias: 1'b1};
			MODE_PD:  sel = '{use_p: 1'b1, use_i: 1'b0, use_d: 1'b1, use_bias: 1'b1};
			MODE_ID:  sel = '{use_p: 1'b0, use_i: 1'b1, use_d: 1'b1, use_bias: 1'b1};
			MODE_PID: sel = '{use_p: 1'b1, use_i: 1'b1, use_d: 1'b1, use_bias: 1'b1};
			MODE_OFF: sel = '0;
			default:  sel = '0;
		endcase
		return sel;
	endfunction

endpackage

FILE: hdl/pscc_if.sv
// ----------------------------------------------------------------------------
// PID steering controller channels
// Valid/ready channel interfaces for sensor samples and controller results.
// ----------------------------------------------------------------------------
interface pscc_sample_if #(
	parameter int SAMPLE_BITS = 10
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface pscc_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pscc_pkg::DRIVE_W-1:0]  drive;
	logic [pscc_pkg::MAG_W-1:0]           magnitude;
	logic                                 direction;

	modport source (output valid, output drive, output magnitude, output direction,
		input ready);
	modport sink (input valid, input drive, input magnitude, input direction,
		output ready);
endinterface

FILE: hdl/pscc_front.sv
// ----------------------------------------------------------------------------
// PID steering controller front end
// Takes one sample a cycle while the queue has room; forms the error, updates
// the clamped integral and the derivative, and queues the three terms.
// ----------------------------------------------------------------------------
module pscc_front #(
	parameter int SAMPLE_BITS = 10,
	parameter int INTEGRAL_BITS = 20,
	localparam int ERR_W = SAMPLE_BITS + 1,
	localparam int DER_W = SAMPLE_BITS + 2,
	localparam int PKT_W = ERR_W + INTEGRAL_BITS + DER_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  logic [SAMPLE_BITS-1:0]            sample,
	input  logic [SAMPLE_BITS-1:0]            setpoint,
	input  logic [pscc_pkg::LIMIT_W-1:0]      integral_limit,
	output logic                              push_valid,
	input  logic                              push_ready,
	output logic [PKT_W-1:0]                  push_data
);

	localparam int SUM_W = (INTEGRAL_BITS > ERR_W ? INTEGRAL_BITS : ERR_W) + 1;
	localparam int CMP_W =
		(INTEGRAL_BITS > pscc_pkg::LIMIT_W + 1 ? INTEGRAL_BITS : pscc_pkg::LIMIT_W + 1) + 1;
	localparam logic signed [SUM_W-1:0] IMAX = SUM_W'({1'b0, {(INTEGRAL_BITS-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] IMIN = ~IMAX;

	logic signed [ERR_W-1:0]         err_d;
	logic signed [ERR_W-1:0]         prev_err_q;
	logic signed [INTEGRAL_BITS-1:0] integ_q;
	logic signed [INTEGRAL_BITS-1:0] integ_sat;
	logic signed [INTEGRAL_BITS-1:0] integ_d;
	logic signed [SUM_W-1:0]         sum;
	logic signed [CMP_W-1:0]         integ_cmp;
	logic signed [CMP_W-1:0]         lim_pos;
	logic signed [CMP_W-1:0]         lim_neg;
	logic signed [DER_W-1:0]         deriv_d;
	logic                            err_pos;
	logic                            err_neg;
	logic                            prev_pos;
	logic                            prev_neg;
	logic                            flip;
	logic                            accept;

	// The queue sets the pace; a beat goes straight in when it has room.
	assign sample_ready = push_ready;
	assign push_valid   = sample_valid;
	assign accept       = sample_valid && push_ready;

	// Error, saturated integral, sign-change test, limit clamp and derivative.
	always_comb begin
		err_d     = $signed({1'b0, setpoint}) - $signed({1'b0, sample});
		sum       = SUM_W'(integ_q) + SUM_W'(err_d);
		if (sum > IMAX) begin
			integ_sat = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
		end else if (sum < IMIN) begin
			integ_sat = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};
		end else begin
			integ_sat = sum[INTEGRAL_BITS-1:0];
		end

		err_neg  = err_d[ERR_W-1];
		err_pos  = !err_d[ERR_W-1] && (|err_d);
		prev_neg = prev_err_q[ERR_W-1];
		prev_pos = !prev_err_q[ERR_W-1] && (|prev_err_q);
		flip     = (err_pos && prev_neg) || (err_neg && prev_pos);

		integ_cmp = CMP_W'(integ_sat);
		lim_pos   = CMP_W'({1'b0, integral_limit});
		lim_neg   = -lim_pos;
		if (!flip && integ_cmp >= lim_pos) begin
			integ_d = lim_pos[INTEGRAL_BITS-1:0];
		end else if (!flip && integ_cmp <= lim_neg) begin
			integ_d = lim_neg[INTEGRAL_BITS-1:0];
		end else begin
			integ_d = integ_sat;
		end

		deriv_d = DER_W'(err_d) - DER_W'(prev_err_q);
	end

	assign push_data = {err_d, integ_d, deriv_d};

	// Loop state advances with every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			integ_q    <= '0;
		end else if (accept) begin
			prev_err_q <= err_d;
			integ_q    <= integ_d;
		end
	end

endmodule

FILE: hdl/pscc_fifo.sv
// ----------------------------------------------------------------------------
// PID steering controller queue
// Short first-in first-out queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
module pscc_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: hdl/pscc_back.sv
// ----------------------------------------------------------------------------
// PID steering controller back end
// Multiplies terms by gains, sums them with the bias, saturates the drive,
// tracks direction, rounds the magnitude; one beat a cycle unless stalled.
// ----------------------------------------------------------------------------
module pscc_back #(
	parameter int SAMPLE_BITS = 10,
	parameter int INTEGRAL_BITS = 20,
	parameter int GAIN_FRAC_BITS = 16,
	localparam int ERR_W = SAMPLE_BITS + 1,
	localparam int DER_W = SAMPLE_BITS + 2,
	localparam int PKT_W = ERR_W + INTEGRAL_BITS + DER_W
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   pop_valid,
	output logic                                   pop_ready,
	input  logic [PKT_W-1:0]                       pop_data,
	input  pscc_pkg::mode_t                        mode,
	input  logic signed [pscc_pkg::GAIN_W-1:0]     gain_p,
	input  logic signed [pscc_pkg::GAIN_W-1:0]     gain_i,
	input  logic signed [pscc_pkg::GAIN_W-1:0]     gain_d,
	input  logic signed [pscc_pkg::GAIN_W-1:0]     bias,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic signed [pscc_pkg::DRIVE_W-1:0]    drive,
	output logic [pscc_pkg::MAG_W-1:0]             magnitude,
	output logic                                   direction
);

	localparam int GW      = pscc_pkg::GAIN_W;
	localparam int DW      = pscc_pkg::DRIVE_W;
	localparam int MW      = pscc_pkg::MAG_W;
	localparam int PP_W    = GW + ERR_W;
	localparam int PI_W    = GW + INTEGRAL_BITS;
	localparam int PD_W    = GW + DER_W;
	localparam int ACC_W   = (PI_W > PD_W ? PI_W : PD_W) + 2;
	localparam int WIDE_W  = ACC_W > DW ? ACC_W : DW;
	localparam logic signed [WIDE_W-1:0] DMAX = WIDE_W'({1'b0, {(DW-1){1'b1}}});
	localparam logic signed [WIDE_W-1:0] DMIN = ~DMAX;
	localparam logic [DW:0] RND_HALF = (DW+1)'(1) << (GAIN_FRAC_BITS - 1);

	pscc_pkg::term_sel_t             sel;
	logic signed [ERR_W-1:0]         err;
	logic signed [INTEGRAL_BITS-1:0] integ;
	logic signed [DER_W-1:0]         deriv;
	logic signed [GW-1:0]            gp;
	logic signed [GW-1:0]            gi;
	logic signed [GW-1:0]            gd;
	logic signed [PP_W-1:0]          prod_p;
	logic signed [PI_W-1:0]          prod_i;
	logic signed [PD_W-1:0]          prod_d;

	logic                            valid_s1;
	logic signed [PP_W-1:0]          prod_p_s1;
	logic signed [PI_W-1:0]          prod_i_s1;
	logic signed [PD_W-1:0]          prod_d_s1;
	logic signed [GW-1:0]            bias_s1;

	logic                            valid_s2;
	logic signed [ACC_W-1:0]         acc_s2;

	logic                            valid_s3;
	logic signed [DW-1:0]            drive_s3;
	logic                            dir_s3;

	logic                            out_valid_q;
	logic signed [DW-1:0]            drive_q;
	logic [MW-1:0]                   mag_q;
	logic                            dir_q;
	logic                            last_dir_q;

	logic                            out_ready;
	logic                            s3_ready;
	logic                            s2_ready;
	logic                            s1_ready;

	logic signed [WIDE_W-1:0]        acc_wide;
	logic signed [DW-1:0]            drive_sat;
	logic                            dir_d;
	logic [DW-1:0]                   abs_d;
	logic [DW:0]                     rnd;
	logic [DW:0]                     shifted;
	logic [MW-1:0]                   mag_d;

	// Stage readiness, from the output register back to the queue.
	assign out_ready = !out_valid_q || result_ready;
	assign s3_ready  = !valid_s3 || out_ready;
	assign s2_ready  = !valid_s2 || s3_ready;
	assign s1_ready  = !valid_s1 || s2_ready;
	assign pop_ready = s1_ready;

	// Unpack the terms, mask the gains that the mode leaves out and multiply.
	always_comb begin
		sel    = pscc_pkg::decode_mode(mode);
		err    = pop_data[PKT_W-1 -: ERR_W];
		integ  = pop_data[DER_W +: INTEGRAL_BITS];
		deriv  = pop_data[DER_W-1:0];
		gp     = sel.use_p ? gain_p : '0;
		gi     = sel.use_i ? gain_i : '0;
		gd     = sel.use_d ? gain_d : '0;
		prod_p = gp * err;
		prod_i = gi * integ;
		prod_d = gd * deriv;
	end

	// Saturate the sum and work out the direction.
	always_comb begin
		acc_wide = WIDE_W'(acc_s2);
		if (acc_wide > DMAX) begin
			drive_sat = DMAX[DW-1:0];
		end else if (acc_wide < DMIN) begin
			drive_sat = DMIN[DW-1:0];
		end else begin
			drive_sat = acc_wide[DW-1:0];
		end
		if (drive_sat[DW-1]) begin
			dir_d = 1'b1;
		end else if (|drive_sat) begin
			dir_d = 1'b0;
		end else begin
			dir_d = last_dir_q;
		end
	end

	// Magnitude, rounded half away from zero and held to the field range.
	always_comb begin
		abs_d   = drive_s3[DW-1] ? DW'(-drive_s3) : drive_s3;
		rnd     = {1'b0, abs_d} + RND_HALF;
		shifted = rnd >> GAIN_FRAC_BITS;
		if (|shifted[DW:MW]) begin
			mag_d = '1;
		end else begin
			mag_d = shifted[MW-1:0];
		end
	end

	// Stage valid flags and held direction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			last_dir_q  <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= pop_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (s3_ready) begin
				valid_s3 <= valid_s2;
			end
			if (out_ready) begin
				out_valid_q <= valid_s3;
			end
			if (s3_ready && valid_s2) begin
				last_dir_q <= dir_d;
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (s1_ready && pop_valid) begin
			prod_p_s1 <= prod_p;
			prod_i_s1 <= prod_i;
			prod_d_s1 <= prod_d;
			bias_s1   <= sel.use_bias ? bias : '0;
		end
		if (s2_ready && valid_s1) begin
			acc_s2 <= ACC_W'(prod_p_s1) + ACC_W'(prod_i_s1) + ACC_W'(prod_d_s1)
				+ ACC_W'(bias_s1);
		end
		if (s3_ready && valid_s2) begin
			drive_s3 <= drive_sat;
			dir_s3   <= dir_d;
		end
		if (out_ready && valid_s3) begin
			drive_q <= drive_s3;
			mag_q   <= mag_d;
			dir_q   <= dir_s3;
		end
	end

	assign result_valid = out_valid_q;
	assign drive        = drive_q;
	assign magnitude    = mag_q;
	assign direction    = dir_q;

endmodule

FILE: hdl/pid_steering_controller_core.sv
// ----------------------------------------------------------------------------
// PID steering controller core
// Fixed-point PID loop on a sensor sample stream with configurable gains,
// bias, mode and integral clamp; gives drive, magnitude and direction.
//
//   Channel   Dir  Payload                              Handshake
//   samples   in   sample                               valid/ready
//   results   out  drive, magnitude, direction          valid/ready
//   wr_*      in   wr_index, wr_data                    wr_en, no wait
//
// Throughput is one beat per cycle while the queue has room; the integral
// and previous error update in the cycle a sample is accepted, which is what
// bounds the rate. A result passes the queue and the multiply, sum, saturate
// and round stages before it leaves the output register.
// Reset clears loop state, queue and stage valids and loads the register
// reset values. samples.ready drops only while the front queue is full.
// ----------------------------------------------------------------------------
module pid_steering_controller_core #(
	parameter int SAMPLE_BITS = 10,
	parameter int GAIN_FRAC_BITS = 16,
	parameter int INTEGRAL_BITS = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	pscc_sample_if.sink                          samples,
	pscc_result_if.source                        results,
	input  logic                                 wr_en,
	input  logic [pscc_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [pscc_pkg::CFG_DATA_W-1:0]      wr_data
);

	localparam int PKT_W = (SAMPLE_BITS + 1) + INTEGRAL_BITS + (SAMPLE_BITS + 2);
	localparam int GW = pscc_pkg::GAIN_W;

	logic [SAMPLE_BITS-1:0]           setpoint_q;
	pscc_pkg::mode_t                  mode_q;
	logic signed [GW-1:0]             gain_p_q;
	logic signed [GW-1:0]             gain_i_q;
	logic signed [GW-1:0]             gain_d_q;
	logic signed [GW-1:0]             bias_q;
	logic [pscc_pkg::LIMIT_W-1:0]     limit_q;

	logic                             push_valid;
	logic                             push_ready;
	logic [PKT_W-1:0]                 push_data;
	logic                             pop_valid;
	logic                             pop_ready;
	logic [PKT_W-1:0]                 pop_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= SAMPLE_BITS'(pscc_pkg::SETPOINT_RESET);
			mode_q     <= pscc_pkg::MODE_P;
			gain_p_q   <= GW'(pscc_pkg::GAIN_P_RESET);
			gain_i_q   <= GW'(pscc_pkg::GAIN_I_RESET);
			gain_d_q   <= GW'(pscc_pkg::GAIN_D_RESET);
			bias_q     <= GW'(pscc_pkg::BIAS_RESET);
			limit_q    <= pscc_pkg::LIMIT_W'(pscc_pkg::LIMIT_RESET);
		end else if (wr_en) begin
			case (pscc_pkg::reg_idx_t'(wr_index))
				pscc_pkg::REG_SETPOINT: setpoint_q <= wr_data[SAMPLE_BITS-1:0];
				pscc_pkg::REG_MODE:     mode_q <= pscc_pkg::mode_t'(wr_data[pscc_pkg::MODE_W-1:0]);
				pscc_pkg::REG_GAIN_P:   gain_p_q <= wr_data;
				pscc_pkg::REG_GAIN_I:   gain_i_q <= wr_data;
				pscc_pkg::REG_GAIN_D:   gain_d_q <= wr_data;
				pscc_pkg::REG_BIAS:     bias_q <= wr_data;
				pscc_pkg::REG_LIMIT:    limit_q <= wr_data[pscc_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Front end: error, integral and derivative.
	pscc_front #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.INTEGRAL_BITS (INTEGRAL_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (samples.valid),
		.sample_ready   (samples.ready),
		.sample         (samples.sample),
		.setpoint       (setpoint_q),
		.integral_limit (limit_q),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_data      (push_data)
	);

	// Queue between the two ends.
	pscc_fifo #(
		.W     (PKT_W),
		.DEPTH (pscc_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_data),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_data)
	);

	// Back end: gains, sum, saturation and output register.
	pscc_back #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.INTEGRAL_BITS  (INTEGRAL_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.mode         (mode_q),
		.gain_p       (gain_p_q),
		.gain_i       (gain_i_q),
		.gain_d       (gain_d_q),
		.bias         (bias_q),
		.result_valid (results.valid),
		.result_ready (results.ready),
		.drive        (results.drive),
		.magnitude    (results.magnitude),
		.direction    (results.direction)
	);

	// A negative drive always points left.
	a_dir_neg: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.drive[pscc_pkg::DRIVE_W-1] |-> results.direction)
		else $error("negative drive without left direction");

	// A positive drive always points right.
	a_dir_pos: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.drive[pscc_pkg::DRIVE_W-1] && (results.drive != '0)
		|-> !results.direction)
		else $error("positive drive without right direction");

	// A zero drive rounds to a zero magnitude.
	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.drive == '0) |-> (results.magnitude == '0))
		else $error("zero drive with nonzero magnitude");

endmodule

FILE: verif/pid_steering_controller_core_tb.sv
// ----------------------------------------------------------------------------
// PID steering controller core testbench
// Streams sensor samples into the core through bursts and gaps while the
// result side stalls on its own pattern. A behavioral copy of the loop
// (integral clamp, sign-change bypass, mode terms, rounding, held direction)
// predicts every result beat, which is checked field by field. The gains,
// bias, setpoint, mode and integral limit are rewritten between phases,
// extremes included, whenever the pipeline has drained.
// ----------------------------------------------------------------------------
module pid_steering_controller_core_tb;
	import pscc_pkg::*;

	localparam int SMP_BITS = 10;
	localparam int FRAC_BITS = 16;
	localparam int INTEG_BITS = 20;
	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 11;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 530;
	localparam int TIMEOUT_CYCLES = 400_000;
	localparam int PRINT_CAP = 100;

	localparam longint INTEG_MAX = (longint'(1) << (INTEG_BITS - 1)) - 1;
	localparam longint INTEG_MIN = -INTEG_MAX - 1;
	localparam longint DRIVE_MAX = (longint'(1) << (DRIVE_W - 1)) - 1;
	localparam longint DRIVE_MIN = -DRIVE_MAX - 1;
	localparam logic [63:0] MAG_MAX = 64'hFFFF_FFFF;
	localparam int SMP_TOP = (1 << SMP_BITS) - 1;

	// Index past the last register; writes to it must be ignored.
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// Direction codes.
	localparam logic DIR_RIGHT = 1'b0;
	localparam logic DIR_LEFT = 1'b1;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic [MAG_W-1:0] magnitude;
		logic direction;
	} steer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic smp_valid = 1'b0;
	logic [SMP_BITS-1:0] smp_data = '0;
	logic res_ready = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;

	pscc_sample_if #(.SAMPLE_BITS(SMP_BITS)) samples_ch ();
	pscc_result_if results_ch ();

	assign samples_ch.valid = smp_valid;
	assign samples_ch.sample = smp_data;
	assign results_ch.ready = res_ready;

	pid_steering_controller_core #(
		.SAMPLE_BITS(SMP_BITS),
		.GAIN_FRAC_BITS(FRAC_BITS),
		.INTEGRAL_BITS(INTEG_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_ch.sink),
		.results(results_ch.source),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// Shadow copy of the register file, loaded with the reset values.
	logic [SMP_BITS-1:0] set_point = SMP_BITS'(SETPOINT_RESET);
	mode_t ctl_mode = MODE_P;
	logic signed [GAIN_W-1:0] gain_p = GAIN_W'(GAIN_P_RESET);
	logic signed [GAIN_W-1:0] gain_i = GAIN_W'(GAIN_I_RESET);
	logic signed [GAIN_W-1:0] gain_d = GAIN_W'(GAIN_D_RESET);
	logic signed [GAIN_W-1:0] bias_q = GAIN_W'(BIAS_RESET);
	logic [LIMIT_W-1:0] int_limit = LIMIT_W'(LIMIT_RESET);

	// Loop state of the predictor.
	logic signed [SMP_BITS:0] prev_error = '0;
	logic signed [INTEG_BITS-1:0] integ_sum = '0;
	logic last_dir = DIR_RIGHT;

	mode_t all_modes [8] = '{MODE_P, MODE_I, MODE_D, MODE_PI, MODE_PD, MODE_ID,
		MODE_PID, MODE_OFF};

	logic [SMP_BITS-1:0] pending_samples [$];
	steer_result_t expected_steer [$];
	bit sample_offered = 1'b0;
	int burst_left = 8;
	int gap_left = 0;
	int ready_cycle = 0;
	int ready_pattern = 0;
	int mismatch_count = 0;

	// Clock generation.
	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// Mirror a register write into the shadow copy, with the same masking.
	function automatic void apply_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SETPOINT: set_point = data[SMP_BITS-1:0];
			REG_MODE:     ctl_mode = mode_t'(data[MODE_W-1:0]);
			REG_GAIN_P:   gain_p = data;
			REG_GAIN_I:   gain_i = data;
			REG_GAIN_D:   gain_d = data;
			REG_BIAS:     bias_q = data;
			REG_LIMIT:    int_limit = data[LIMIT_W-1:0];
			default:      ;
		endcase
	endfunction

	// One step of the steering loop: update the integral and error history,
	// then form drive, rounded magnitude and the held direction.
	function automatic steer_result_t predict_steering(logic [SMP_BITS-1:0] smp);
		longint err, prev, isum, lim, deriv, p_term, i_term, d_term, drv, absd;
		logic [63:0] mag;
		logic sign_flip;
		steer_result_t res;
		err = longint'(set_point) - longint'(smp);
		prev = longint'(prev_error);
		isum = longint'(integ_sum) + err;
		if (isum > INTEG_MAX)
			isum = INTEG_MAX;
		else if (isum < INTEG_MIN)
			isum = INTEG_MIN;
		// The clamp is bypassed on a step where the error changes sign.
		sign_flip = (err > 0 && prev < 0) || (err < 0 && prev > 0);
		lim = longint'(int_limit);
		if (!sign_flip) begin
			if (isum >= lim)
				isum = lim;
			else if (isum <= -lim)
				isum = -lim;
		end
		deriv = err - prev;
		prev_error = err[SMP_BITS:0];
		integ_sum = isum[INTEG_BITS-1:0];

		p_term = longint'(gain_p) * err;
		i_term = longint'(gain_i) * isum;
		d_term = longint'(gain_d) * deriv;
		case (ctl_mode)
			MODE_P:   drv = p_term + longint'(bias_q);
			MODE_I:   drv = i_term + longint'(bias_q);
			MODE_D:   drv = d_term + longint'(bias_q);
			MODE_PI:  drv = p_term + i_term + longint'(bias_q);
			MODE_PD:  drv = p_term + d_term + longint'(bias_q);
			MODE_ID:  drv = i_term + d_term + longint'(bias_q);
			MODE_PID: drv = p_term + i_term + d_term + longint'(bias_q);
			default:  drv = 0;
		endcase
		if (drv > DRIVE_MAX)
			drv = DRIVE_MAX;
		else if (drv < DRIVE_MIN)
			drv = DRIVE_MIN;

		// Round half away from zero on the magnitude.
		absd = (drv < 0) ? -drv : drv;
		mag = ($unsigned(absd) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (mag > MAG_MAX)
			mag = MAG_MAX;

		if (drv > 0)
			last_dir = DIR_RIGHT;
		else if (drv < 0)
			last_dir = DIR_LEFT;

		res.drive = drv[DRIVE_W-1:0];
		res.magnitude = mag[MAG_W-1:0];
		res.direction = last_dir;
		return res;
	endfunction

	// Sample driver: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			smp_valid <= 1'b0;
		end else if (sample_offered) begin
			// Hold the beat until it is taken.
		end else if (gap_left > 0) begin
			smp_valid <= 1'b0;
			gap_left--;
		end else if (pending_samples.size() != 0) begin
			smp_valid <= 1'b1;
			smp_data <= pending_samples[0];
			sample_offered = 1'b1;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			end
		end else begin
			smp_valid <= 1'b0;
		end
	end

	// Result side stalls on one of four patterns, re-picked at random as ready_cycle advances.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (ready_cycle % 48 == 0)
				ready_pattern = $urandom_range(0, 3);
			case (ready_pattern)
				0:       res_ready <= 1'b1;
				1:       res_ready <= 1'($urandom_range(0, 1));
				2:       res_ready <= ((ready_cycle % 9) >= 4);
				default: res_ready <= ($urandom_range(0, 7) != 0);
			endcase
			ready_cycle++;
		end
	end

	// Monitor: check result beats and predict on every accepted sample beat.
	always @(posedge clk) begin
		steer_result_t want;
		if (arst_n) begin
			if (results_ch.valid && res_ready) begin
				if (expected_steer.size() == 0) begin
					report_mismatch("result beat with no expectation waiting");
				end else begin
					want = expected_steer.pop_front();
					if (results_ch.drive !== want.drive)
						report_mismatch($sformatf("drive %0d, expected %0d",
							results_ch.drive, want.drive));
					if (results_ch.magnitude !== want.magnitude)
						report_mismatch($sformatf("magnitude %0d, expected %0d",
							results_ch.magnitude, want.magnitude));
					if (results_ch.direction !== want.direction)
						report_mismatch($sformatf("direction %0b, expected %0b",
							results_ch.direction, want.direction));
				end
			end
			if (smp_valid && samples_ch.ready) begin
				expected_steer.push_back(predict_steering(pending_samples.pop_front()));
				sample_offered = 1'b0;
			end
		end
	end

	// Register write, one per cycle; wr_en stays high across back-to-back writes.
	task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic cfg_close();
		@(negedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every sample has produced its result, then let the pipe settle.
	task automatic wait_idle();
		while (pending_samples.size() != 0 || expected_steer.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0:       return 24'h80_0000;
			1:       return 24'h7F_FFFF;
			2:       return '0;
			3:       return CFG_DATA_W'($urandom_range(0, 4000) - 2000);
			default: return CFG_DATA_W'($urandom());
		endcase
	endfunction

	// Upper data bits are random so that the register masking is exercised.
	function automatic logic [CFG_DATA_W-1:0] pick_setpoint();
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom());
		case ($urandom_range(0, 5))
			0:       data[SMP_BITS-1:0] = '0;
			1:       data[SMP_BITS-1:0] = '1;
			default: ;
		endcase
		return data;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_limit();
		logic [CFG_DATA_W-1:0] data;
		data = CFG_DATA_W'($urandom());
		case ($urandom_range(0, 6))
			0:       data[LIMIT_W-1:0] = '0;
			1:       data[LIMIT_W-1:0] = '1;
			2, 3:    data[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 64));
			4, 5:    data[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 4000));
			default: ;
		endcase
		return data;
	endfunction

	// Stimulus and end of run.
	initial begin
		int rand_items;
		int n_items;
		int style;
		int val;
		bit above;
		bit first_pass;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, mode P: zero error, sign flips and both sample extremes.
		pending_samples.push_back(SMP_BITS'(SETPOINT_RESET));
		pending_samples.push_back('0);
		pending_samples.push_back('1);
		pending_samples.push_back('1);
		pending_samples.push_back('0);

		// Every other mode, output-off included, with a flip per phase.
		for (int k = 1; k < 8; k++) begin
			wait_idle();
			cfg_write(REG_MODE, CFG_DATA_W'(all_modes[k]));
			cfg_close();
			pending_samples.push_back('1);
			pending_samples.push_back('0);
		end

		// Zero limit, extreme gains and bias, a wide setpoint write and a write
		// to an index past the register file.
		wait_idle();
		cfg_write(REG_LIMIT, 24'hF8_0000);
		cfg_write(REG_MODE, CFG_DATA_W'(MODE_PID));
		cfg_write(REG_GAIN_P, 24'h7F_FFFF);
		cfg_write(REG_GAIN_I, 24'h80_0000);
		cfg_write(REG_GAIN_D, 24'h80_0000);
		cfg_write(REG_BIAS, 24'h7F_FFFF);
		cfg_write(REG_SETPOINT, 24'hFF_FC64);
		cfg_write(REG_UNUSED, 24'hFF_FFFF);
		cfg_close();
		pending_samples.push_back(SMP_BITS'(50));
		pending_samples.push_back(SMP_BITS'(40));
		pending_samples.push_back('1);
		pending_samples.push_back(SMP_BITS'(1022));

		// Random phases: new settings, then a stream of samples of one shape.
		rand_items = 0;
		first_pass = 1'b1;
		while (rand_items < RANDOM_ITEMS) begin
			wait_idle();
			if (first_pass || $urandom_range(0, 2) == 0)
				cfg_write(REG_SETPOINT, pick_setpoint());
			if (first_pass || $urandom_range(0, 1) == 0)
				cfg_write(REG_MODE, CFG_DATA_W'(all_modes[$urandom_range(0, 7)]));
			if (first_pass || $urandom_range(0, 2) == 0)
				cfg_write(REG_GAIN_P, pick_gain());
			if (first_pass || $urandom_range(0, 2) == 0)
				cfg_write(REG_GAIN_I, pick_gain());
			if (first_pass || $urandom_range(0, 2) == 0)
				cfg_write(REG_GAIN_D, pick_gain());
			if (first_pass || $urandom_range(0, 2) == 0)
				cfg_write(REG_BIAS, pick_gain());
			if (first_pass || $urandom_range(0, 2) == 0)
				cfg_write(REG_LIMIT, pick_limit());
			if ($urandom_range(0, 9) == 0)
				cfg_write(REG_UNUSED, CFG_DATA_W'($urandom()));
			cfg_close();
			first_pass = 1'b0;

			n_items = $urandom_range(8, 40);
			style = $urandom_range(0, 3);
			above = 1'($urandom_range(0, 1));
			for (int i = 0; i < n_items; i++) begin
				case (style)
					// Full-range samples.
					0: val = $urandom_range(0, SMP_TOP);
					// Hovering around the setpoint, so the error flips sign often.
					1: begin
						val = int'(set_point) + $urandom_range(0, 16) - 8;
						if (val < 0)
							val = 0;
						else if (val > SMP_TOP)
							val = SMP_TOP;
					end
					// Error keeps one sign, so the limit clamp holds.
					2: val = above ? $urandom_range(int'(set_point), SMP_TOP)
						: $urandom_range(0, int'(set_point));
					// Rail-to-rail swings.
					default: val = ($urandom_range(0, 1) != 0) ? SMP_TOP : 0;
				endcase
				pending_samples.push_back(SMP_BITS'(val));
			end
			rand_items += n_items;
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard stop in case the pipeline hangs.
	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/pscc_pkg.sv
hdl/pscc_if.sv
hdl/pscc_front.sv
hdl/pscc_fifo.sv
hdl/pscc_back.sv
hdl/pid_steering_controller_core.sv
verif/pid_steering_controller_core_tb.sv
